// ===== hw/rtl/tspt_pkg.sv =====
package tspt_pkg;

   localparam int FRAC = 30;
   localparam int VAL_W = 34;
   localparam int THICK_W = 24;
   localparam int ANGLE_IN_W = 16;
   localparam int OUT_W = 32;
   localparam int MAX_STEPS = 24;
   localparam longint GAIN_BASE = 64'd652032874;
   localparam longint GAIN_TAIL = 64'd434688583;
   // dividend is a 24-bit magnitude shifted up by FRAC
   localparam int QUO_W = 54;

   localparam logic [0:0] CSR_THICKNESS = 1'b0;
   localparam logic [0:0] CSR_TILT = 1'b1;

   localparam logic [31:0] ATAN_TURN32 [MAX_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef logic signed [VAL_W-1:0] val_type;

   typedef struct packed {
      logic [THICK_W-1:0] depth;
      logic               neg_num;
      logic               back;
      logic               zero_den;
   } tag_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] path_thickness;
      logic                    grazing;
      logic                    exits_back;
   } rsp_type;

   function automatic val_type gain_start(input int steps);
      longint g;
      begin
         g = GAIN_BASE + (GAIN_TAIL >>> (2 * steps));
         return val_type'(g);
      end
   endfunction

endpackage

// ===== hw/rtl/tspt_if.sv =====
interface tspt_req_if;
   logic                                valid;
   logic                                ready;
   logic [tspt_pkg::ANGLE_IN_W-1:0]     polar_angle;
   logic [tspt_pkg::ANGLE_IN_W-1:0]     azimuth_angle;
   logic [tspt_pkg::THICK_W-1:0]        hit_depth;
   modport source (output valid, polar_angle, azimuth_angle, hit_depth, input ready);
   modport sink (input valid, polar_angle, azimuth_angle, hit_depth, output ready);
endinterface

interface tspt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tspt_pkg::OUT_W-1:0]   path_thickness;
   logic                                grazing;
   logic                                exits_back;
   modport source (output valid, path_thickness, grazing, exits_back, input ready);
   modport sink (input valid, path_thickness, grazing, exits_back, output ready);
endinterface

// ===== hw/rtl/tspt_cordic_cell.sv =====
// one rotation step on three independent angles, registered
module tspt_cordic_cell #(
   parameter int STEP = 0,
   parameter int ANGLE_BITS = 16,
   parameter int PW = 8
) (
   input  logic                     clock,
   input  logic                     en,
   input  tspt_pkg::val_type        x_in [3],
   input  tspt_pkg::val_type        y_in [3],
   input  logic signed [ANGLE_BITS:0] z_in [3],
   input  logic [1:0]               quad_in [3],
   input  logic [PW-1:0]            pass_in,
   output tspt_pkg::val_type        x_ff [3],
   output tspt_pkg::val_type        y_ff [3],
   output logic signed [ANGLE_BITS:0] z_ff [3],
   output logic [1:0]               quad_ff [3],
   output logic [PW-1:0]            pass_ff
);
   localparam logic [32:0] ROUND = 33'(tspt_pkg::ATAN_TURN32[STEP])
                                 + (33'd1 << (31 - ANGLE_BITS));
   localparam logic signed [ANGLE_BITS:0] E = (ANGLE_BITS+1)'(ROUND >> (32 - ANGLE_BITS));

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            if (!z_in[k][ANGLE_BITS]) begin
               x_ff[k] <= x_in[k] - (y_in[k] >>> STEP);
               y_ff[k] <= y_in[k] + (x_in[k] >>> STEP);
               z_ff[k] <= z_in[k] - E;
            end else begin
               x_ff[k] <= x_in[k] + (y_in[k] >>> STEP);
               y_ff[k] <= y_in[k] - (x_in[k] >>> STEP);
               z_ff[k] <= z_in[k] + E;
            end
            quad_ff[k] <= quad_in[k];
         end
         pass_ff <= pass_in;
      end
   end
endmodule

// ===== hw/rtl/tspt_div_cell.sv =====
// one restoring division bit
module tspt_div_cell #(
   parameter int PW = 8
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [tspt_pkg::QUO_W-1:0]    rem_in,
   input  logic [tspt_pkg::QUO_W-1:0]    num_in,
   input  logic [tspt_pkg::VAL_W-1:0]    den_in,
   input  logic [tspt_pkg::QUO_W-1:0]    quo_in,
   input  logic [PW-1:0]                 pass_in,
   output logic [tspt_pkg::QUO_W-1:0]    rem_ff,
   output logic [tspt_pkg::QUO_W-1:0]    num_ff,
   output logic [tspt_pkg::VAL_W-1:0]    den_ff,
   output logic [tspt_pkg::QUO_W-1:0]    quo_ff,
   output logic [PW-1:0]                 pass_ff
);
   localparam int W = tspt_pkg::QUO_W;
   logic [W:0] trial;
   logic [W:0] diff;

   always_comb begin
      trial = {rem_in, num_in[W-1]};
      diff = trial - (W+1)'(den_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= diff[W] ? trial[W-1:0] : diff[W-1:0];
         quo_ff  <= {quo_in[W-2:0], ~diff[W]};
         num_ff  <= {num_in[W-2:0], 1'b0};
         den_ff  <= den_in;
         pass_ff <= pass_in;
      end
   end
endmodule

// ===== hw/rtl/tilted_slab_path_thickness_top.sv =====
// Path length through a tilted slab. Fully pipelined: one transaction is taken every
// clock and its result passes through the chain of CORDIC rotation cells (three angles
// side by side), a two-stage product path for the cosine, a 54-cell restoring divider
// chain and the output register. The whole chain advances when the output register is
// free or being read, so back-pressure stalls it without loss.
module tilted_slab_path_thickness_top #(
   parameter int ANGLE_BITS = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   tspt_req_if.sink     req,
   tspt_rsp_if.source   rsp,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [23:0]  csr_wdata
);
   localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
   localparam int QW = tspt_pkg::QUO_W;
   localparam int VW = tspt_pkg::VAL_W;
   localparam int PW = tspt_pkg::THICK_W * 2;
   localparam int DEPTH = STEPS + 2 + QW;

   logic [23:0] thick_ff;
   logic [15:0] tilt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thick_ff <= '0;
         tilt_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == tspt_pkg::CSR_THICKNESS) thick_ff <= csr_wdata;
         else if (csr_index == tspt_pkg::CSR_TILT) tilt_ff <= csr_wdata[15:0];
      end
   end

   // valid chain and stall
   logic [DEPTH-1:0] vld_ff;
   logic en;
   logic rsp_valid_ff;
   assign en = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[DEPTH-2:0], req.valid};
   end

   // cordic chain
   tspt_pkg::val_type x_s [STEPS+1][3];
   tspt_pkg::val_type y_s [STEPS+1][3];
   logic signed [ANGLE_BITS:0] z_s [STEPS+1][3];
   logic [1:0] q_s [STEPS+1][3];
   logic [PW-1:0] p_s [STEPS+1];
   logic [ANGLE_BITS-1:0] ph [3];

   always_comb begin
      ph[0] = ANGLE_BITS'((64'(req.polar_angle) << ANGLE_BITS) >> 16);
      ph[1] = ANGLE_BITS'((64'(req.azimuth_angle) << ANGLE_BITS) >> 16);
      ph[2] = ANGLE_BITS'((64'(tilt_ff) << ANGLE_BITS) >> 16);
      for (int k = 0; k < 3; k++) begin
         x_s[0][k] = tspt_pkg::gain_start(STEPS);
         y_s[0][k] = '0;
         z_s[0][k] = (ANGLE_BITS+1)'(ph[k][ANGLE_BITS-3:0]);
         q_s[0][k] = ph[k][ANGLE_BITS-1:ANGLE_BITS-2];
      end
      p_s[0] = {thick_ff, req.hit_depth};
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_cordic
      tspt_cordic_cell #(.STEP(i), .ANGLE_BITS(ANGLE_BITS), .PW(PW)) u_cell (
         .clock(clock), .en(en),
         .x_in(x_s[i]), .y_in(y_s[i]), .z_in(z_s[i]), .quad_in(q_s[i]), .pass_in(p_s[i]),
         .x_ff(x_s[i+1]), .y_ff(y_s[i+1]), .z_ff(z_s[i+1]), .quad_ff(q_s[i+1]),
         .pass_ff(p_s[i+1]));
   end

   tspt_pkg::val_type c_v [3];
   tspt_pkg::val_type s_v [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         case (q_s[STEPS][k])
            2'd0: begin c_v[k] = x_s[STEPS][k]; s_v[k] = y_s[STEPS][k]; end
            2'd1: begin c_v[k] = -y_s[STEPS][k]; s_v[k] = x_s[STEPS][k]; end
            2'd2: begin c_v[k] = -x_s[STEPS][k]; s_v[k] = -y_s[STEPS][k]; end
            default: begin c_v[k] = y_s[STEPS][k]; s_v[k] = -x_s[STEPS][k]; end
         endcase
      end
   end

   // products: stage a forms cti*ctt and sti*cpa, stage b multiplies by stt and adds
   tspt_pkg::val_type a_ctt_ff, a_sc_ff, a_stt_ff;
   logic [PW-1:0] a_p_ff;
   logic signed [2*VW-1:0] m1, m2, m3;
   tspt_pkg::val_type b_cz_ff;
   logic [PW-1:0] b_p_ff;
   always_comb begin
      m1 = (2*VW)'(c_v[0]) * (2*VW)'(c_v[2]);
      m2 = (2*VW)'(s_v[0]) * (2*VW)'(c_v[1]);
   end
   always_ff @(posedge clock) begin
      if (en) begin
         a_ctt_ff <= VW'(m1 >>> tspt_pkg::FRAC);
         a_sc_ff  <= VW'(m2 >>> tspt_pkg::FRAC);
         a_stt_ff <= s_v[2];
         a_p_ff   <= p_s[STEPS];
      end
   end
   always_comb m3 = (2*VW)'(a_sc_ff) * (2*VW)'(a_stt_ff);
   always_ff @(posedge clock) begin
      if (en) begin
         b_cz_ff <= a_ctt_ff + VW'(m3 >>> tspt_pkg::FRAC);
         b_p_ff  <= a_p_ff;
      end
   end

   // numerator and divider setup
   logic back;
   logic signed [25:0] num;
   logic [24:0] an;
   logic [VW-1:0] ad;
   tspt_pkg::tag_type tg;
   always_comb begin
      back = b_cz_ff[VW-1];
      if (back) num = -26'(b_p_ff[23:0]);
      else num = 26'(b_p_ff[PW-1:24]) - 26'(b_p_ff[23:0]);
      an = num[25] ? 25'(-num) : 25'(num);
      ad = back ? VW'(-b_cz_ff) : VW'(b_cz_ff);
      tg.depth = '0;
      tg.neg_num = num[25];
      tg.back = back;
      tg.zero_den = (b_cz_ff == '0);
   end

   logic [QW-1:0] r_s [QW+1];
   logic [QW-1:0] n_s [QW+1];
   logic [VW-1:0] d_s [QW+1];
   logic [QW-1:0] qq_s [QW+1];
   logic [PW-1:0] t_s [QW+1];
   always_comb begin
      r_s[0] = '0;
      n_s[0] = QW'(an) << tspt_pkg::FRAC;
      d_s[0] = ad;
      qq_s[0] = '0;
      t_s[0] = PW'({(num == '0), tg});
   end
   for (genvar i = 0; i < QW; i++) begin : g_div
      tspt_div_cell #(.PW(PW)) u_div (
         .clock(clock), .en(en),
         .rem_in(r_s[i]), .num_in(n_s[i]), .den_in(d_s[i]), .quo_in(qq_s[i]),
         .pass_in(t_s[i]),
         .rem_ff(r_s[i+1]), .num_ff(n_s[i+1]), .den_ff(d_s[i+1]), .quo_ff(qq_s[i+1]),
         .pass_ff(t_s[i+1]));
   end

   // finish
   tspt_pkg::tag_type tf;
   logic num_zero;
   logic neg;
   tspt_pkg::rsp_type res;
   logic [QW-1:0] quo;
   always_comb begin
      {num_zero, tf} = ($bits(tf)+1)'(t_s[QW]);
      quo = qq_s[QW];
      neg = tf.neg_num != tf.back;
      res.exits_back = tf.back;
      res.grazing = 1'b0;
      if (tf.zero_den) begin
         res.grazing = 1'b1;
         res.exits_back = 1'b0;
         if (num_zero) res.path_thickness = '0;
         else if (tf.neg_num) res.path_thickness = 32'sh80000000;
         else res.path_thickness = 32'sh7FFFFFFF;
      end else if (neg) begin
         if (quo > QW'(64'h80000000)) begin
            res.grazing = 1'b1;
            res.path_thickness = 32'sh80000000;
         end else res.path_thickness = 32'(-quo);
      end else begin
         if (quo > QW'(64'h7FFFFFFF)) begin
            res.grazing = 1'b1;
            res.path_thickness = 32'sh7FFFFFFF;
         end else res.path_thickness = quo[31:0];
      end
   end

   tspt_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= vld_ff[DEPTH-1];
   end
   always_ff @(posedge clock) if (en) rsp_ff <= res;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.path_thickness = rsp_ff.path_thickness;
   assign rsp.grazing = rsp_ff.grazing;
   assign rsp.exits_back = rsp_ff.exits_back;

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.path_thickness))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("ready mismatch");
   a_back: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.exits_back |-> !rsp.path_thickness[31] || rsp.path_thickness == '0
      || rsp.grazing)
      else $error("back exit with negative path");
endmodule

// ===== tb/tspt_path_checker.sv =====
module tspt_path_checker (
   input  logic  clock,
   input  logic  reset,
   tspt_req_if   req,
   tspt_rsp_if   rsp,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [23:0]  csr_wdata,
   output int    fail_count,
   output int    pending
);
   localparam int N_STEPS = 16;

   logic [23:0] thickness_q;
   logic [15:0] tilt_q;
   tspt_pkg::rsp_type expected_paths[$];
   int          mismatches;

   function automatic void turn_sincos(input logic [15:0] a, output longint c,
                                       output longint s);
      longint x, y, z, e, dx, dy;
      logic [1:0] quad;
      quad = a[15:14];
      z = longint'(a[13:0]);
      x = tspt_pkg::GAIN_BASE + (tspt_pkg::GAIN_TAIL >> (2 * N_STEPS));
      y = 0;
      for (int i = 0; i < N_STEPS; i++) begin
         e = (longint'(tspt_pkg::ATAN_TURN32[i]) + (64'sd1 <<< 15)) >>> 16;
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - e;
         end else begin
            x = x + dx; y = y - dy; z = z + e;
         end
      end
      case (quad)
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic tspt_pkg::rsp_type slab_path(input logic [15:0] polar,
                                                   input logic [15:0] azim,
                                                   input logic [23:0] depth);
      longint cti, sti, cpa, spa, ctt, stt, cz, num, an, ad, q, res;
      logic neg;
      tspt_pkg::rsp_type r;
      turn_sincos(polar, cti, sti);
      turn_sincos(azim, cpa, spa);
      turn_sincos(tilt_q, ctt, stt);
      cz = ((cti * ctt) >>> 30) + ((((sti * cpa) >>> 30) * stt) >>> 30);
      r.grazing = 1'b0;
      r.exits_back = (cz < 0);
      num = (cz < 0) ? -longint'(depth) : longint'(thickness_q) - longint'(depth);
      if (cz == 0) begin
         r.grazing = 1'b1;
         res = (num > 0) ? 64'sd2147483647 : ((num < 0) ? -64'sd2147483648 : 64'sd0);
      end else begin
         neg = (num < 0) != (cz < 0);
         an = (num < 0) ? -num : num;
         ad = (cz < 0) ? -cz : cz;
         q = (an <<< 30) / ad;
         if (neg) begin
            if (q > 64'sd2147483648) begin
               r.grazing = 1'b1; res = -64'sd2147483648;
            end else res = -q;
         end else begin
            if (q > 64'sd2147483647) begin
               r.grazing = 1'b1; res = 64'sd2147483647;
            end else res = q;
         end
      end
      r.path_thickness = res[31:0];
      return r;
   endfunction

   assign pending = expected_paths.size();

   always @(posedge clock) begin
      tspt_pkg::rsp_type got, want;
      if (reset) begin
         thickness_q <= '0;
         tilt_q <= '0;
         fail_count <= 0;
         mismatches = 0;
         expected_paths.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == tspt_pkg::CSR_THICKNESS) thickness_q <= csr_wdata;
            else if (csr_index == tspt_pkg::CSR_TILT) tilt_q <= csr_wdata[15:0];
         end
         if (req.valid && req.ready)
            expected_paths.push_back(slab_path(req.polar_angle, req.azimuth_angle,
                                               req.hit_depth));
         if (rsp.valid && rsp.ready) begin
            got.path_thickness = rsp.path_thickness;
            got.grazing = rsp.grazing;
            got.exits_back = rsp.exits_back;
            if (expected_paths.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transaction: path %0d grazing %0b back %0b",
                           got.path_thickness, got.grazing, got.exits_back);
            end else begin
               want = expected_paths.pop_front();
               if (got != want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected path %0d grazing %0b back %0b, got %0d %0b %0b",
                              want.path_thickness, want.grazing, want.exits_back,
                              got.path_thickness, got.grazing, got.exits_back);
               end
            end
         end
         fail_count <= mismatches;
      end
   end
endmodule

// ===== tb/tb_tilted_slab_path_thickness_top.sv =====
module tb_tilted_slab_path_thickness_top;
   localparam int LATENCY = 16 + 57;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [23:0] csr_wdata;
   int          fail_count;
   int          pending;
   logic        long_hold;
   int          burst_left;

   tspt_req_if req ();
   tspt_rsp_if rsp ();

   tilted_slab_path_thickness_top dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   tspt_path_checker path_check (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("Regression FAIL");
      $finish;
   end

   // receiver stall pattern, with an occasional long hold-off
   initial begin
      int mode, left, hold;
      rsp.ready = 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp.ready <= 1'b0;
            for (hold = 0; hold < 300; hold++) @(negedge clock);
            long_hold = 1'b0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(10, 200);
         end
         left--;
         case (mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 1) == 1);
            2: rsp.ready <= (left % 4 != 0);
            default: rsp.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   task automatic send_hit(input logic [15:0] polar, input logic [15:0] azim,
                           input logic [23:0] depth);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req.valid <= 1'b1;
      req.polar_angle <= polar;
      req.azimuth_angle <= azim;
      req.hit_depth <= depth;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [23:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_hits(input logic [23:0] thick, input int count);
      logic [15:0] polar;
      logic [23:0] depth;
      for (int n = 0; n < count; n++) begin
         polar = 16'($urandom);
         case ($urandom_range(0, 5))
            0: polar = 16'({polar[15:14], 14'd0} + $urandom_range(0, 3) - 2);
            1: depth = 24'($urandom_range(0, 16'hFFFF));
            default: ;
         endcase
         case ($urandom_range(0, 3))
            0: depth = 24'($urandom);
            1: depth = 24'(thick + $urandom_range(0, 64) - 32);
            2: depth = 24'($urandom_range(0, thick));
            default: depth = {$urandom_range(0, 1) ? 24'hFFFFFF : 24'd0};
         endcase
         send_hit(polar, 16'($urandom), depth);
      end
   endtask

   initial begin
      logic [23:0] thick_set[6];
      logic [15:0] tilt_set[6];
      logic [15:0] corners[5];
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.polar_angle = '0;
      req.azimuth_angle = '0;
      req.hit_depth = '0;
      long_hold = 1'b0;
      burst_left = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: quadrant corners, zero thickness and tilt from reset
      corners = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
      foreach (corners[k]) send_hit(corners[k], 16'h0000, 24'd0);
      send_hit(16'h4000, 16'h4000, 24'd0);
      send_hit(16'h4000, 16'h4000, 24'h000100);
      send_hit(16'h8000, 16'hFFFF, 24'hFFFFFF);
      drain();
      write_csr(tspt_pkg::CSR_THICKNESS, 24'hFFFFFF);
      write_csr(tspt_pkg::CSR_TILT, 24'h000000);
      send_hit(16'h0000, 16'h0000, 24'h000000);
      send_hit(16'h3FFF, 16'h0000, 24'h000000);
      send_hit(16'h4000, 16'h0000, 24'h000010);
      send_hit(16'h8000, 16'h1234, 24'hFFFFFF);
      send_hit(16'hC001, 16'h8000, 24'h800000);
      drain();
      write_csr(tspt_pkg::CSR_THICKNESS, 24'h000400);
      write_csr(tspt_pkg::CSR_TILT, 24'h002000);
      send_hit(16'h1000, 16'h0000, 24'h000800);
      send_hit(16'h1000, 16'h8000, 24'h000400);
      send_hit(16'hF000, 16'h4000, 24'hFFFFFF);
      send_hit(16'h6000, 16'h0000, 24'h000200);
      send_hit(16'hFFFF, 16'hFFFF, 24'h000001);
      drain();

      thick_set = '{24'd0, 24'hFFFFFF, 24'h001000, 24'h000000, 24'h7FFFFF, 24'h0C8000};
      tilt_set = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'h1555, 16'hC000};
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(tspt_pkg::CSR_THICKNESS, (ph == 3) ? 24'($urandom) : thick_set[ph]);
         write_csr(tspt_pkg::CSR_TILT, (ph == 3) ? 24'(16'($urandom)) : 24'(tilt_set[ph]));
         random_hits(thick_set[ph], 130);
         if (ph == 2) long_hold = 1'b1;
         if (ph == 4) begin
            req.valid <= 1'b0;
            while (pending != 0) @(negedge clock);
         end
         random_hits(thick_set[ph], 130);
         drain();
      end

      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 20) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
